/* rtl/i2a_pkg.sv */
// shared constants, types and helpers for the integer to ascii radix converter
package i2a_pkg;

    localparam int VALUE_W        = 64;
    localparam int DEC_DIGITS     = 20;
    localparam int HEX_DIGITS     = 16;
    localparam int BCD_W          = DEC_DIGITS * 4;
    localparam int POS_W          = $clog2(DEC_DIGITS);
    localparam int PAD_W          = 5;
    localparam int CHAR_W         = 8;
    localparam int S_TDATA_W      = 72;
    localparam int MAX_DIGITS_DEF = 20;

    localparam logic [1:0] CMD_UDEC = 2'd0;
    localparam logic [1:0] CMD_SDEC = 2'd1;
    localparam logic [1:0] CMD_HEX  = 2'd2;
    localparam logic [1:0] CMD_PTR  = 2'd3;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHR_X     = 8'h78;

    typedef struct packed {
        logic [BCD_W-1:0]  dig;
        logic [PAD_W-1:0]  pad;
        logic [POS_W-1:0]  top_pos;
        logic [1:0]        pre_cnt;
        logic [CHAR_W-1:0] pre0;
        logic [CHAR_W-1:0] pre1;
    } emit_load_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHR_ZERO + {4'b0, d};
        end else begin
            c = CHR_A + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

/* rtl/i2a_digits.sv */
// bit-serial binary to bcd converter, with direct nibble load for hex
module i2a_digits (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         hex,
    input  logic [i2a_pkg::VALUE_W-1:0]  value,
    output logic                         busy,
    output logic [i2a_pkg::BCD_W-1:0]    bcd
);
    import i2a_pkg::*;

    localparam int CntW = $clog2(VALUE_W + 1);

    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [VALUE_W-1:0] sh_reg, sh_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   adj;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        sh_next  = sh_reg;
        bcd_next = bcd_reg;
        if (start) begin
            if (hex) begin
                cnt_next = '0;
                bcd_next = {{(BCD_W - VALUE_W){1'b0}}, value};
            end else begin
                cnt_next = CntW'(VALUE_W);
                sh_next  = value;
                bcd_next = '0;
            end
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], sh_reg[VALUE_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign busy = (cnt_reg != '0);
    assign bcd  = bcd_reg;

endmodule

/* rtl/i2a_emit.sv */
// character sequencer: prefix, zero suppression and padding, output register
module i2a_emit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  i2a_pkg::emit_load_t          load_info,
    output logic                         busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]   m_tdata,   // char_out
    output logic                         m_tlast    // last
);
    import i2a_pkg::*;

    logic               active_reg, active_next;
    logic               started_reg, started_next;
    logic [BCD_W-1:0]   dig_reg, dig_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PAD_W-1:0]   pad_reg, pad_next;
    logic [1:0]         pre_cnt_reg, pre_cnt_next;
    logic [CHAR_W-1:0]  pre0_reg, pre0_next;
    logic [CHAR_W-1:0]  pre1_reg, pre1_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               slot;
    logic [3:0]         cur;
    logic               emit_ok;

    assign slot    = !m_tvalid_reg || m_tready;
    assign cur     = dig_reg[BCD_W-1 -: 4];
    assign emit_ok = started_reg || (cur != 4'd0) || (PAD_W'(pos_reg) < pad_reg)
                     || (pos_reg == '0);

    always_comb begin
        active_next   = active_reg;
        started_next  = started_reg;
        dig_next      = dig_reg;
        pos_next      = pos_reg;
        pad_next      = pad_reg;
        pre_cnt_next  = pre_cnt_reg;
        pre0_next     = pre0_reg;
        pre1_next     = pre1_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (load) begin
            active_next  = 1'b1;
            started_next = 1'b0;
            dig_next     = load_info.dig;
            pos_next     = load_info.top_pos;
            pad_next     = load_info.pad;
            pre_cnt_next = load_info.pre_cnt;
            pre0_next    = load_info.pre0;
            pre1_next    = load_info.pre1;
        end else if (active_reg && slot) begin
            if (pre_cnt_reg != 2'd0) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = pre0_reg;
                m_tlast_next  = 1'b0;
                pre0_next     = pre1_reg;
                pre_cnt_next  = pre_cnt_reg - 2'd1;
            end else begin
                if (emit_ok) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = digit_char(cur);
                    m_tlast_next  = (pos_reg == '0);
                    started_next  = 1'b1;
                end
                dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                pos_next = pos_reg - 1'b1;
                if (pos_reg == '0) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        started_reg <= started_next;
        dig_reg     <= dig_next;
        pos_reg     <= pos_next;
        pad_reg     <= pad_next;
        pre_cnt_reg <= pre_cnt_next;
        pre0_reg    <= pre0_next;
        pre1_reg    <= pre1_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign busy     = active_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !active_reg)
        else $error("load while sequencer active");

    a_final_digit_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !load && slot && pre_cnt_reg == 2'd0 && pos_reg == '0) |=> !active_reg)
        else $error("sequencer still active after final digit");

    a_final_digit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !load && slot && pre_cnt_reg == 2'd0 && pos_reg == '0)
        |=> (m_tvalid_reg && m_tlast_reg))
        else $error("final digit not flagged last");

endmodule

/* rtl/int_to_ascii_radix_converter.sv */
// top level: integer to ascii radix converter
// decimal item: bit-serial bcd conversion of all 64 value bits, then a load into the emitter once
// the conversion has ended and the emitter is idle; hex and pointer items skip the conversion
// the emitter steps through each prefix character and then each of the 20 digit positions,
// dropped leading zeros included; output stalls hold it
// a new item is accepted once the previous one is loaded, conversion overlapping its output
// aresetn (synchronous, active low) clears control state and drops tvalid on the output
module int_to_ascii_radix_converter #(
    parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [i2a_pkg::S_TDATA_W-1:0]  s_tdata,   // cmd[1:0], value[65:2], pad_width[70:66]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]     m_tdata,   // char_out
    output logic                           m_tlast    // last
);
    import i2a_pkg::*;

    localparam int Cap = (MAX_DIGITS < DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    logic               state_reg, state_next;
    emit_load_t         info_reg, info_next;
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] value;
    logic [PAD_W-1:0]   pad_in;
    logic [PAD_W-1:0]   pad_sat;
    logic               neg;
    logic               is_hex;
    logic               accept;
    logic               dig_busy;
    logic [BCD_W-1:0]   bcd;
    logic               emit_busy;
    logic               load;
    emit_load_t         load_info;

    assign cmd     = s_tdata[1:0];
    assign value   = s_tdata[VALUE_W+1:2];
    assign pad_in  = s_tdata[VALUE_W+PAD_W+1:VALUE_W+2];
    assign pad_sat = (pad_in > PAD_W'(Cap)) ? PAD_W'(Cap) : pad_in;
    assign neg     = (cmd == CMD_SDEC) && value[VALUE_W-1];
    assign is_hex  = (cmd == CMD_HEX) || (cmd == CMD_PTR);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_WAIT) && !dig_busy && !emit_busy;

    always_comb begin
        state_next = state_reg;
        info_next  = info_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next        = ST_WAIT;
                    info_next.dig     = '0;
                    info_next.pad     = pad_sat;
                    info_next.top_pos = POS_W'(DEC_DIGITS - 1);
                    info_next.pre_cnt = 2'd0;
                    info_next.pre0    = CHR_ZERO;
                    info_next.pre1    = CHR_X;
                    if (cmd == CMD_PTR) begin
                        info_next.pad     = PAD_W'(HEX_DIGITS);
                        info_next.pre_cnt = 2'd2;
                    end else if (neg) begin
                        info_next.pre_cnt = 2'd1;
                        info_next.pre0    = CHR_MINUS;
                    end
                end
            end
            ST_WAIT: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        info_reg <= info_next;
    end

    always_comb begin
        load_info     = info_reg;
        load_info.dig = bcd;
    end

    i2a_digits u_digits (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .hex     (is_hex),
        .value   (neg ? (~value + 1'b1) : value),
        .busy    (dig_busy),
        .bcd     (bcd)
    );

    i2a_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .load_info (load_info),
        .busy      (emit_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* test/int_to_ascii_radix_converter_checker.sv */
// checker for the integer to ascii radix converter: predicts the text of each item and compares
module int_to_ascii_radix_converter_checker #(
    parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [i2a_pkg::S_TDATA_W-1:0]   s_tdata,   // cmd[1:0], value[65:2], pad_width[70:66]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [i2a_pkg::CHAR_W-1:0]      m_tdata,   // char_out
    input  logic                            m_tlast,   // last
    output int                              failures,
    output int                              pending,
    output int                              chars_checked,
    output int                              items_taken
);
    import i2a_pkg::*;

    logic [CHAR_W-1:0] text_char_q[$];
    logic              text_last_q[$];
    int                err_count;
    int                char_count;
    int                item_count;

    initial begin
        err_count     = 0;
        char_count    = 0;
        item_count    = 0;
        failures      = 0;
        pending       = 0;
        chars_checked = 0;
        items_taken   = 0;
    end

    // builds the expected characters of one item and queues them
    task automatic spell_value(input logic [1:0] cmd, input logic [VALUE_W-1:0] value,
                               input logic [PAD_W-1:0] pad);
        logic [CHAR_W-1:0]  text [0:23];
        logic [CHAR_W-1:0]  rev [0:23];
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] d;
        int                 len;
        int                 n;
        int                 width;
        int                 cap;
        int                 i;
        len   = 0;
        mag   = value;
        radix = 64'd10;
        width = pad;
        cap   = (MAX_DIGITS < 20) ? MAX_DIGITS : 20;
        case (cmd)
            CMD_SDEC: begin
                if (value[VALUE_W-1]) begin
                    text[len] = CHR_MINUS;
                    len++;
                    mag = -value;
                end
            end
            CMD_HEX: begin
                radix = 64'd16;
            end
            CMD_PTR: begin
                text[0] = CHR_ZERO;
                text[1] = CHR_X;
                len     = 2;
                radix   = 64'd16;
                width   = 16;
            end
            default: begin
            end
        endcase
        if (width > cap) width = cap;
        n = 0;
        do begin
            d = mag % radix;
            rev[n] = (d < 64'd10) ? CHR_ZERO + d[7:0] : CHR_A + d[7:0] - 8'd10;
            n++;
            mag = mag / radix;
        end while (mag != 0 && n < 20);
        while (n < width) begin
            rev[n] = CHR_ZERO;
            n++;
        end
        while (n > 0) begin
            n--;
            text[len] = rev[n];
            len++;
        end
        for (i = 0; i < len; i++) begin
            text_char_q.push_back(text[i]);
            text_last_q.push_back(i == len - 1);
        end
    endtask

    always @(posedge aclk) begin
        logic [CHAR_W-1:0] want_char;
        logic              want_last;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                char_count++;
                if (text_char_q.size() == 0) begin
                    if (err_count < 10)
                        $display("unexpected char %h last %b with nothing pending",
                                 m_tdata, m_tlast);
                    err_count++;
                end else begin
                    want_char = text_char_q.pop_front();
                    want_last = text_last_q.pop_front();
                    if (m_tdata !== want_char || m_tlast !== want_last) begin
                        if (err_count < 10)
                            $display("char mismatch: expected %h last %b, got %h last %b",
                                     want_char, want_last, m_tdata, m_tlast);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item_count++;
                spell_value(s_tdata[1:0], s_tdata[65:2], s_tdata[70:66]);
            end
        end
        failures      <= err_count;
        pending       <= text_char_q.size();
        chars_checked <= char_count;
        items_taken   <= item_count;
    end

endmodule

/* test/int_to_ascii_radix_converter_test.sv */
// testbench top for the integer to ascii radix converter: stimulus, stalls and verdict
module int_to_ascii_radix_converter_test;
    import i2a_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // cmd[1:0], value[65:2], pad_width[70:66]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CHAR_W-1:0]    m_tdata;   // char_out
    logic                 m_tlast;   // last

    int failures;
    int pending;
    int chars_checked;
    int items_taken;
    bit tx_calm;
    bit rx_calm;
    int rx_hold;

    int_to_ascii_radix_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    int_to_ascii_radix_converter_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .failures      (failures),
        .pending       (pending),
        .chars_checked (chars_checked),
        .items_taken   (items_taken)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    task automatic send_number(input logic [1:0] cmd, input logic [VALUE_W-1:0] value,
                               input logic [PAD_W-1:0] pad);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pad, value, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 5))
            0:       v = {$urandom, $urandom};
            1:       v = 64'($urandom_range(0, 1000));
            2:       v = 64'd1 << k;
            3:       v = (64'd1 << k) - 64'd1;
            4:       v = ~(64'($urandom_range(0, 1000)));
            default: v = {$urandom, $urandom} >> k;
        endcase
        return v;
    endfunction

    // receiver side stalls
    initial begin
        m_tready = 1'b0;
        rx_calm  = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            rx_hold = rx_calm ? 0 : $urandom_range(0, 12);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    initial begin
        #8000000;
        $display("timeout with %0d characters still pending", pending);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [1:0]       cmd;
        logic [PAD_W-1:0] pad;
        int               i;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        tx_calm  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items
        send_number(CMD_UDEC, 64'd0, 5'd0);
        send_number(CMD_UDEC, 64'd0, 5'd20);
        send_number(CMD_UDEC, 64'hffff_ffff_ffff_ffff, 5'd0);
        send_number(CMD_UDEC, 64'd12345, 5'd8);
        send_number(CMD_UDEC, 64'd7, 5'd31);
        send_number(CMD_UDEC, 64'd1234, 5'd2);
        send_number(CMD_SDEC, 64'd0, 5'd0);
        send_number(CMD_SDEC, 64'hffff_ffff_ffff_ffff, 5'd0);
        send_number(CMD_SDEC, 64'h8000_0000_0000_0000, 5'd0);
        send_number(CMD_SDEC, 64'h7fff_ffff_ffff_ffff, 5'd0);
        send_number(CMD_SDEC, -64'd42, 5'd20);
        send_number(CMD_SDEC, -64'd5, 5'd25);
        send_number(CMD_SDEC, 64'h8000_0000_0000_0000, 5'd31);
        send_number(CMD_HEX, 64'd0, 5'd0);
        send_number(CMD_HEX, 64'hffff_ffff_ffff_ffff, 5'd0);
        send_number(CMD_HEX, 64'hdead_beef, 5'd12);
        send_number(CMD_HEX, 64'habc, 5'd31);
        send_number(CMD_HEX, 64'hffff_ffff_ffff_ffff, 5'd19);
        send_number(CMD_PTR, 64'd0, 5'd0);
        send_number(CMD_PTR, 64'hffff_ffff_ffff_ffff, 5'd31);
        send_number(CMD_PTR, 64'h1234, 5'd5);
        wait_drained();

        // random items
        for (i = 0; i < 160; i++) begin
            cmd = 2'($urandom_range(0, 3));
            pad = ($urandom_range(0, 7) == 0) ? PAD_W'($urandom_range(21, 31))
                                               : PAD_W'($urandom_range(0, 20));
            send_number(cmd, pick_value(), pad);
            if (i == 80) wait_drained();
        end
        wait_drained();
        repeat (150) @(posedge aclk);

        $display("checked %0d characters from %0d items: all four conversion kinds,",
                 chars_checked, items_taken);
        $display("pad widths 0 to 31, extreme values, random stalls on both sides");
        if (failures == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d characters missing", failures, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
